@@ sv/h264_nal_frame_counter_macros.svh @@
// ---------------------------------------------------------------------------
// h264_nal_frame_counter_macros: assertion macros
// Concurrent assertion wrappers, sampled on clock; compiled out when
// NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef H264_NAL_FRAME_COUNTER_MACROS_SVH
`define H264_NAL_FRAME_COUNTER_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked only outside reset
`define HNFC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked at every edge, reset included
`define HNFC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define HNFC_ASSERT(lbl, prop, msg)
`define HNFC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ sv/hnfc_pkg.sv @@
// ---------------------------------------------------------------------------
// hnfc_pkg: shared types and constants of the NAL frame counter
// Header codes, match phases, categories and the byte scanner function.
// ---------------------------------------------------------------------------
package hnfc_pkg;

   localparam int HDR_BITS       = 8;
   localparam int HIST_DEPTH     = 1 << HDR_BITS;
   localparam int COUNT_BITS_DEF = 32;
   localparam int OUT_BITS       = 32;
   localparam int MARK_BIT       = 7;

   // header byte codes
   localparam logic [HDR_BITS-1:0] HDR_IDR_A    = 8'h25;
   localparam logic [HDR_BITS-1:0] HDR_IDR_B    = 8'h45;
   localparam logic [HDR_BITS-1:0] HDR_IDR_C    = 8'h65;
   localparam logic [HDR_BITS-1:0] HDR_SLICE_A  = 8'h01;
   localparam logic [HDR_BITS-1:0] HDR_SLICE_B  = 8'h21;
   localparam logic [HDR_BITS-1:0] HDR_SLICE_C  = 8'h41;
   localparam logic [HDR_BITS-1:0] HDR_SLICE_D  = 8'h61;
   localparam logic [HDR_BITS-1:0] HDR_AUD      = 8'h09;
   localparam logic [HDR_BITS-1:0] HDR_SPS      = 8'h67;
   localparam logic [HDR_BITS-1:0] HDR_PPS      = 8'h68;
   localparam logic [HDR_BITS-1:0] BYTE_ZERO    = 8'h00;
   localparam logic [HDR_BITS-1:0] BYTE_ONE     = 8'h01;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_ZERO1  = 3'd1,
      PH_ZEROS  = 3'd2,
      PH_HEADER = 3'd3,
      PH_CHECK  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      CAT_IDR     = 2'd0,
      CAT_NON_IDR = 2'd1,
      CAT_PARAM   = 2'd2,
      CAT_OTHER   = 2'd3
   } cat_type;

   // scanner to counters: one check beat
   typedef struct packed {
      logic                check;   // check beat accepted
      logic                count;   // header counted (mark bit set)
      logic [HDR_BITS-1:0] header;
      cat_type             cat;
   } scan_evt_type;

   function automatic phase_type scan_byte(phase_type ph, logic [HDR_BITS-1:0] b);
      phase_type nx;
      case (ph)
         PH_ZEROS: begin
            if (b == BYTE_ZERO)     nx = PH_ZEROS;
            else if (b == BYTE_ONE) nx = PH_HEADER;
            else                    nx = PH_IDLE;
         end
         PH_ZERO1: nx = (b == BYTE_ZERO) ? PH_ZEROS : PH_IDLE;
         default:  nx = (b == BYTE_ZERO) ? PH_ZERO1 : PH_IDLE;
      endcase
      return nx;
   endfunction

   function automatic cat_type classify(logic [HDR_BITS-1:0] h);
      cat_type c;
      case (h) inside
         HDR_IDR_A, HDR_IDR_B, HDR_IDR_C:                c = CAT_IDR;
         HDR_SLICE_A, HDR_SLICE_B, HDR_SLICE_C, HDR_SLICE_D: c = CAT_NON_IDR;
         HDR_AUD, HDR_SPS, HDR_PPS:                      c = CAT_PARAM;
         default:                                        c = CAT_OTHER;
      endcase
      return c;
   endfunction

endpackage

@@ sv/hnfc_if.sv @@
// ---------------------------------------------------------------------------
// hnfc_if: stream channels of the NAL frame counter
// Byte channel in, counted-header result channel out; valid/ready.
// ---------------------------------------------------------------------------
interface hnfc_req_if;
   logic                         valid;
   logic                         ready;
   logic [hnfc_pkg::HDR_BITS-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface hnfc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hnfc_pkg::HDR_BITS-1:0] nal_header;
   logic [1:0]                    category;
   logic [hnfc_pkg::OUT_BITS-1:0] type_count;
   logic [hnfc_pkg::OUT_BITS-1:0] frame_count;
   logic [hnfc_pkg::OUT_BITS-1:0] max_gop;

   modport source (output valid, output nal_header, output category, output type_count,
                   output frame_count, output max_gop, input ready);
   modport sink   (input valid, input nal_header, input category, input type_count,
                   input frame_count, input max_gop, output ready);
endinterface

@@ sv/h264_nal_frame_counter.sv @@
// ---------------------------------------------------------------------------
// h264_nal_frame_counter: Annex B start code parser and frame counter
// Byte-serial scan for 00 00 01, per-header histogram in memory, frame and
// GOP statistics; one result beat per counted header.
// ---------------------------------------------------------------------------
//   channel  dir  beat payload
//   req      in   data_byte: one stream byte
//   rsp      out  nal_header, category, type_count, frame_count, max_gop
//
// One byte per cycle unless rsp stalls a check byte; its result is registered.
// The histogram entry of a header is read when the header byte is taken and is
// ready for the check beat; the write-back lands at least two beats before the
// next check beat, so the read-modify-write needs no forwarding.
// Reset clears scanner, counters and the histogram valid bits at once; there is
// no clearing pass.
// A result waiting on rsp stalls only a check byte; other bytes keep flowing.
// ---------------------------------------------------------------------------
`include "h264_nal_frame_counter_macros.svh"

module h264_nal_frame_counter #(
   parameter int COUNT_BITS = hnfc_pkg::COUNT_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   hnfc_req_if.sink   req,
   hnfc_rsp_if.source rsp
);

   logic                          beat;
   logic                          at_check;
   logic [hnfc_pkg::HDR_BITS-1:0] rd_addr;
   hnfc_pkg::scan_evt_type        evt;
   logic [COUNT_BITS-1:0]         type_count;
   logic [COUNT_BITS-1:0]         frames_in;
   logic [COUNT_BITS-1:0]         gop_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [hnfc_pkg::HDR_BITS-1:0] header_ff;
   hnfc_pkg::cat_type             cat_ff;
   logic [hnfc_pkg::OUT_BITS-1:0] type_count_ff, frames_ff, gop_ff;

   // only a check byte can produce a result, so only it waits on the output
   assign req.ready = !rsp_valid_ff || rsp.ready || !at_check;
   assign beat      = req.valid && req.ready;

   hnfc_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .beat      (beat),
      .data_byte (req.data_byte),
      .at_check  (at_check),
      .rd_addr   (rd_addr),
      .evt       (evt)
   );

   hnfc_hist #(.COUNT_BITS(COUNT_BITS)) u_hist (
      .clock     (clock),
      .reset     (reset),
      .rd_addr   (rd_addr),
      .evt       (evt),
      .new_count (type_count)
   );

   hnfc_stats #(.COUNT_BITS(COUNT_BITS)) u_stats (
      .clock     (clock),
      .reset     (reset),
      .evt       (evt),
      .frames_in (frames_in),
      .gop_in    (gop_in)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp.ready) rsp_valid_in = 1'b0;
      if (evt.count) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (evt.count) begin
         header_ff     <= evt.header;
         cat_ff        <= evt.cat;
         type_count_ff <= hnfc_pkg::OUT_BITS'(type_count);
         frames_ff     <= hnfc_pkg::OUT_BITS'(frames_in);
         gop_ff        <= hnfc_pkg::OUT_BITS'(gop_in);
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.nal_header  = header_ff;
   assign rsp.category    = cat_ff;
   assign rsp.type_count  = type_count_ff;
   assign rsp.frame_count = frames_ff;
   assign rsp.max_gop     = gop_ff;

   // a count only ever comes from a check beat
   `HNFC_ASSERT_ALWAYS(a_count_on_check, evt.count |-> evt.check, "count without check beat")
   // the histogram read was aimed at the header that is written back
   `HNFC_ASSERT(a_rmw_addr, evt.count |-> $past(rd_addr) == evt.header, "histogram read misaligned")
   // a new result never overwrites one still waiting
   `HNFC_ASSERT(a_no_overrun, evt.count |-> (!rsp_valid_ff || rsp.ready), "result overrun")

endmodule

@@ sv/hnfc_scan.sv @@
// ---------------------------------------------------------------------------
// hnfc_scan: start code scanner
// Tracks 00 00 01, holds the header byte and classifies it on the check beat.
// ---------------------------------------------------------------------------
module hnfc_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          beat,        // input beat accepted
   input  logic [hnfc_pkg::HDR_BITS-1:0] data_byte,
   output logic                          at_check,
   output logic [hnfc_pkg::HDR_BITS-1:0] rd_addr,
   output hnfc_pkg::scan_evt_type        evt
);

   hnfc_pkg::phase_type           phase_ff, phase_in;
   logic [hnfc_pkg::HDR_BITS-1:0] held_ff, held_in;
   hnfc_pkg::cat_type             cat;
   logic                          marked;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hnfc_pkg::PH_IDLE;
         held_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   always_comb begin
      cat        = hnfc_pkg::classify(held_ff);
      marked     = data_byte[hnfc_pkg::MARK_BIT];
      phase_in   = phase_ff;
      held_in    = held_ff;
      evt.check  = 1'b0;
      evt.count  = 1'b0;
      evt.header = held_ff;
      evt.cat    = cat;
      if (beat) begin
         case (phase_ff)
            hnfc_pkg::PH_HEADER: begin
               held_in  = data_byte;
               phase_in = hnfc_pkg::PH_CHECK;
            end
            hnfc_pkg::PH_CHECK: begin
               evt.check = 1'b1;
               evt.count = marked;
               // frames, and marked parameter sets, swallow both bytes
               if (cat == hnfc_pkg::CAT_IDR || cat == hnfc_pkg::CAT_NON_IDR ||
                   (cat == hnfc_pkg::CAT_PARAM && marked)) begin
                  phase_in = hnfc_pkg::PH_IDLE;
               end else begin
                  phase_in = hnfc_pkg::scan_byte(
                     hnfc_pkg::scan_byte(hnfc_pkg::PH_IDLE, held_ff), data_byte);
               end
            end
            default: phase_in = hnfc_pkg::scan_byte(phase_ff, data_byte);
         endcase
      end
   end

   assign at_check = (phase_ff == hnfc_pkg::PH_CHECK);
   // follow the header byte so its count is read by the check beat
   assign rd_addr  = (beat && phase_ff == hnfc_pkg::PH_HEADER) ? data_byte : held_ff;

endmodule

@@ sv/hnfc_hist.sv @@
// ---------------------------------------------------------------------------
// hnfc_hist: per-header histogram memory
// Registered read, saturating increment and write-back on a counted header.
// ---------------------------------------------------------------------------
module hnfc_hist #(
   parameter int COUNT_BITS = hnfc_pkg::COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [hnfc_pkg::HDR_BITS-1:0] rd_addr,
   input  hnfc_pkg::scan_evt_type        evt,
   output logic [COUNT_BITS-1:0]         new_count
);

   logic [COUNT_BITS-1:0]           mem_ff [hnfc_pkg::HIST_DEPTH];
   logic [hnfc_pkg::HIST_DEPTH-1:0] valid_ff;
   logic [COUNT_BITS-1:0]           rd_data_ff;
   logic                            rd_valid_ff;
   logic [COUNT_BITS-1:0]           old_count;

   always_ff @(posedge clock) begin
      if (evt.count) mem_ff[evt.header] <= new_count;
      rd_data_ff <= mem_ff[rd_addr];
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (evt.count) valid_ff[evt.header] <= 1'b1;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign old_count = rd_valid_ff ? rd_data_ff : '0;
   assign new_count = (&old_count) ? old_count : old_count + COUNT_BITS'(1);

endmodule

@@ sv/hnfc_stats.sv @@
// ---------------------------------------------------------------------------
// hnfc_stats: frame and GOP counters
// Saturating frame count, frames since last IDR and largest IDR gap.
// ---------------------------------------------------------------------------
module hnfc_stats #(
   parameter int COUNT_BITS = hnfc_pkg::COUNT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hnfc_pkg::scan_evt_type evt,
   output logic [COUNT_BITS-1:0]  frames_in,
   output logic [COUNT_BITS-1:0]  gop_in
);

   logic [COUNT_BITS-1:0] frames_ff, since_ff, gop_ff, since_in, since_inc;
   logic                  is_frame, is_idr, frames_full, step, gap_larger;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= '0;
         since_ff  <= '0;
         gop_ff    <= '0;
      end else begin
         frames_ff <= frames_in;
         since_ff  <= since_in;
         gop_ff    <= gop_in;
      end
   end

   // since_ff tracks frames_ff minus the last IDR position; it never wraps
   always_comb begin
      is_idr      = evt.count && evt.cat == hnfc_pkg::CAT_IDR;
      is_frame    = is_idr || (evt.count && evt.cat == hnfc_pkg::CAT_NON_IDR);
      frames_full = &frames_ff;
      step        = is_frame && !frames_full;
      since_inc   = since_ff + COUNT_BITS'(1);
      frames_in   = step ? frames_ff + COUNT_BITS'(1) : frames_ff;
      gap_larger  = frames_full ? (since_ff > gop_ff) : (since_ff >= gop_ff);
      gop_in      = gop_ff;
      since_in    = step ? since_inc : since_ff;
      if (is_idr) begin
         if (gap_larger) gop_in = frames_full ? since_ff : since_inc;
         since_in = '0;
      end
   end

endmodule
